// ===== rtl/core/dffc_pkg.sv =====
package dffc_pkg;

   typedef enum logic [1:0] {
      KIND_DEC32 = 2'd0,
      KIND_DEC40 = 2'd1,
      KIND_ENC32 = 2'd2,
      KIND_ENC40 = 2'd3
   } kind_type;

   localparam int OperandWidth = 64;
   localparam int FracWidth    = 52;
   localparam int DblBias      = 1023;
   localparam logic [7:0] ExpZero = 8'h80;
   localparam logic [7:0] ExpMax  = 8'h7F;

   // Stage 1 to stage 2: classified operand
   typedef struct packed {
      kind_type               kind;
      logic                   sign;
      logic                   is_zero;
      logic                   is_special;
      logic                   is_nan;
      logic                   is_denorm;
      logic [10:0]            bexp;
      logic [FracWidth-1:0]   frac;
      logic [5:0]             lead;
      logic [OperandWidth-1:0] operand;
   } dffc_s1_type;

   // Stage 2 to stage 3: normalised fraction, true exponent and decode result
   typedef struct packed {
      kind_type               kind;
      logic                   sign;
      logic                   is_zero;
      logic                   is_special;
      logic                   is_nan;
      logic signed [12:0]     exp;
      logic [FracWidth-1:0]   frac;
      logic [OperandWidth-1:0] dec_result;
   } dffc_s2_type;

endpackage

// ===== rtl/core/dffc_classify.sv =====
module dffc_classify (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  logic [1:0]                in_kind,
   input  logic [63:0]               in_operand,
   output logic                      out_valid,
   output dffc_pkg::dffc_s1_type     out_data
);

   logic                  valid_ff;
   dffc_pkg::dffc_s1_type data_ff, data_in;
   logic [5:0]            lead;

   // Find the highest set fraction bit for denormals
   always_comb begin
      lead = '0;
      for (int i = 0; i < 52; i++) begin
         if (in_operand[i]) lead = 6'(i);
      end
   end

   always_comb begin
      data_in.kind       = dffc_pkg::kind_type'(in_kind);
      data_in.sign       = in_operand[63];
      data_in.bexp       = in_operand[62:52];
      data_in.frac       = in_operand[51:0];
      data_in.is_zero    = (in_operand[62:0] == '0);
      data_in.is_special = (in_operand[62:52] == 11'h7FF);
      data_in.is_nan     = (in_operand[51:0] != '0);
      data_in.is_denorm  = (in_operand[62:52] == '0);
      data_in.lead       = lead;
      data_in.operand    = in_operand;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/dffc_normalise.sv =====
module dffc_normalise (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  dffc_pkg::dffc_s1_type     in_data,
   output logic                      out_valid,
   output dffc_pkg::dffc_s2_type     out_data
);

   logic                  valid_ff;
   dffc_pkg::dffc_s2_type data_ff, data_in;
   logic                  dec40;
   logic [39:0]           word;
   logic signed [7:0]     dexp;
   logic                  dsign;
   logic [30:0]           dm;
   logic [30:0]           dneg;
   logic [51:0]           dfrac;
   logic signed [12:0]    dbe;
   logic [103:0]          shifted;

   always_comb begin
      dec40 = (in_data.kind == dffc_pkg::KIND_DEC40);
      word  = in_data.operand[39:0];
      if (dec40) begin
         dexp  = $signed(word[39:32]);
         dsign = word[31];
         dm    = word[30:0];
      end else begin
         dexp  = $signed(word[31:24]);
         dsign = word[23];
         dm    = {8'd0, word[22:0]};
      end
      dneg = (dec40 ? 31'h0 : 31'h0080_0000) - dm;
      if (!dec40) dneg = {8'd0, dneg[22:0]};
      dbe = 13'(dexp) + 13'sd1023;
      if (!dsign) begin
         dfrac = dec40 ? {dm, 21'd0} : {dm[22:0], 29'd0};
      end else if (dm == '0) begin
         dfrac = '0;
         dbe   = dbe + 13'sd1;
      end else begin
         dfrac = dec40 ? {dneg, 21'd0} : {dneg[22:0], 29'd0};
      end
      data_in.dec_result = (dexp == -8'sd128) ? 64'd0
                         : {dsign, dbe[10:0], dfrac};

      shifted = {52'd0, in_data.frac} << (7'd52 - {1'b0, in_data.lead});
      data_in.kind       = in_data.kind;
      data_in.sign       = in_data.sign;
      data_in.is_zero    = in_data.is_zero;
      data_in.is_special = in_data.is_special;
      data_in.is_nan     = in_data.is_nan;
      if (in_data.is_denorm) begin
         data_in.exp  = 13'($signed({7'd0, in_data.lead})) - 13'sd1074;
         data_in.frac = shifted[51:0];
      end else begin
         data_in.exp  = $signed({2'b00, in_data.bexp}) - 13'sd1023;
         data_in.frac = in_data.frac;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/core/dffc_pack.sv =====
module dffc_pack (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      adv,
   input  logic                      in_valid,
   input  dffc_pkg::dffc_s2_type     in_data,
   output logic                      out_valid,
   output logic [63:0]               out_result
);

   logic        valid_ff;
   logic [63:0] result_ff, result_in;
   logic        enc40;
   logic [52:0] base;
   logic [52:0] sum;
   logic [31:0] m;
   logic [7:0]  e8;

   always_comb begin
      enc40 = (in_data.kind == dffc_pkg::KIND_ENC40);
      base  = in_data.sign ? (53'h10_0000_0000_0000 - {1'b0, in_data.frac})
                           : {1'b0, in_data.frac};
      sum   = base + (enc40 ? 53'h10_0000 : 53'h1000_0000);
      m     = enc40 ? sum[52:21] : {8'd0, sum[52:29]};
      if (enc40) begin
         if (m > 32'h7FFF_FFFF) m = 32'h7FFF_FFFF;
      end else begin
         if (m > 32'h007F_FFFF) m = 32'h007F_FFFF;
      end
      if (in_data.exp < -13'sd127)     e8 = 8'h81;
      else if (in_data.exp > 13'sd127) e8 = dffc_pkg::ExpMax;
      else                              e8 = in_data.exp[7:0];

      case (in_data.kind)
         dffc_pkg::KIND_DEC32, dffc_pkg::KIND_DEC40: begin
            result_in = in_data.dec_result;
         end
         dffc_pkg::KIND_ENC32: begin
            if (in_data.is_zero)
               result_in = {32'd0, dffc_pkg::ExpZero, 24'd0};
            else if (in_data.is_special)
               result_in = {32'd0, dffc_pkg::ExpMax,
                            in_data.sign & ~in_data.is_nan, 23'd0};
            else
               result_in = {32'd0, e8, in_data.sign, m[22:0]};
         end
         default: begin
            if (in_data.is_zero)
               result_in = {24'd0, dffc_pkg::ExpZero, 32'd0};
            else if (in_data.is_special)
               result_in = {24'd0, dffc_pkg::ExpMax,
                            in_data.sign & ~in_data.is_nan, 31'd0};
            else
               result_in = {24'd0, e8, in_data.sign, m[30:0]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) result_ff <= result_in;
   end

   assign out_valid  = valid_ff;
   assign out_result = result_ff;

endmodule

// ===== rtl/core/dsp_float_format_converter.sv =====
// Converts single words between the DSP floating-point format (8-bit two's
// complement exponent, sign, 23- or 31-bit mantissa) and IEEE double bit
// patterns; req_kind picks decode32, decode40, encode32 or encode40. The
// converter is a three-stage pipeline (classify, normalise, pack) and takes
// one beat every cycle unless the pipe holds; each beat passes through the
// classify, normalise and pack registers in turn. The whole pipe holds while
// the output is stalled and its last stage is full, so req_stall follows
// rsp_stall only then; bubbles inside the pipe hold along with it. No
// configuration, no state beyond the pipe.
module dsp_float_format_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_kind,
   input  logic [63:0] req_operand,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_result
);

   logic                  adv;
   logic                  s1_valid, s2_valid;
   dffc_pkg::dffc_s1_type s1_data;
   dffc_pkg::dffc_s2_type s2_data;

   // Advance the pipe unless a finished beat waits on a stalled output
   assign adv       = ~(rsp_valid & rsp_stall);
   assign req_stall = ~adv;

   dffc_classify u_classify (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(req_valid), .in_kind(req_kind), .in_operand(req_operand),
      .out_valid(s1_valid), .out_data(s1_data)
   );

   dffc_normalise u_normalise (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(s1_valid), .in_data(s1_data),
      .out_valid(s2_valid), .out_data(s2_data)
   );

   dffc_pack u_pack (
      .clock(clock), .reset(reset), .adv(adv),
      .in_valid(s2_valid), .in_data(s2_data),
      .out_valid(rsp_valid), .out_result(rsp_result)
   );

`ifndef NO_ASSERTIONS
   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result))
      else $error("stalled result changed");
   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with empty output");
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall ##1 !req_stall ##1 !req_stall |=> rsp_valid)
      else $error("beat lost in pipe");
`endif

endmodule

// ===== verif/dsp_float_format_converter_tb.sv =====
module dsp_float_format_converter_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int IdleLimit = 2000;
   localparam int DrainCycles = 8;

   // Expected-result store: holds one predicted word per accepted request beat
   class conversion_scoreboard;
      logic [63:0] pending_words[$];
      int          error_count;

      // Decode a DSP word with a mantissa of mbits bits into IEEE double bits
      function automatic logic [63:0] dsp_to_double(logic [63:0] word, int mbits);
         logic [7:0]  ebits;
         logic        sgn;
         logic [63:0] mant;
         logic [63:0] dbl_exp;
         ebits = 8'((word >> (mbits + 1)) & 64'hFF);
         sgn   = word[mbits];
         mant  = word & ((64'd1 << mbits) - 1);
         if (ebits == dffc_pkg::ExpZero) return 64'd0;
         dbl_exp = 64'($signed({{56{ebits[7]}}, ebits}) + dffc_pkg::DblBias);
         if (!sgn) return (dbl_exp << 52) | (mant << (52 - mbits));
         if (mant == 0) return {1'b1, 63'd0} | ((dbl_exp + 1) << 52);
         return {1'b1, 63'd0} | (dbl_exp << 52)
                | (((64'd1 << mbits) - mant) << (52 - mbits));
      endfunction

      // Encode IEEE double bits into a DSP word with a mantissa of mbits bits
      function automatic logic [63:0] double_to_dsp(logic [63:0] bits, int mbits);
         logic        sgn;
         logic [10:0] bexp;
         logic [63:0] frac;
         logic [63:0] mant;
         logic [63:0] mmax;
         int          drop;
         int          lead;
         int          true_exp;
         sgn  = bits[63];
         bexp = bits[62:52];
         frac = {12'd0, bits[51:0]};
         mmax = (64'd1 << mbits) - 1;
         drop = 52 - mbits;
         if (bexp == 0 && frac == 0) return 64'(dffc_pkg::ExpZero) << (mbits + 1);
         if (bexp == 11'h7FF)
            return (64'(dffc_pkg::ExpMax) << (mbits + 1))
                   | (64'(frac == 0 ? sgn : 1'b0) << mbits);
         if (bexp == 0) begin
            // normalise a denormal: find its leading one
            lead = 51;
            while (lead > 0 && !frac[lead]) lead--;
            true_exp = lead - 1074;
            frac = (frac << (52 - lead)) & 64'hF_FFFF_FFFF_FFFF;
         end else begin
            true_exp = int'(bexp) - dffc_pkg::DblBias;
         end
         if (!sgn) mant = (frac + (64'd1 << (drop - 1))) >> drop;
         else mant = (((64'd1 << 52) - frac) + (64'd1 << (drop - 1))) >> drop;
         if (mant > mmax) mant = mmax;
         if (true_exp < -127) true_exp = -127;
         if (true_exp > 127) true_exp = 127;
         return (64'(true_exp[7:0]) << (mbits + 1)) | (64'(sgn) << mbits) | mant;
      endfunction

      function void note_request(dffc_pkg::kind_type kind, logic [63:0] operand);
         logic [63:0] word;
         case (kind)
            dffc_pkg::KIND_DEC32: word = dsp_to_double(operand & 64'hFFFF_FFFF, 23);
            dffc_pkg::KIND_DEC40: word = dsp_to_double(operand & 64'hFF_FFFF_FFFF, 31);
            dffc_pkg::KIND_ENC32: word = double_to_dsp(operand, 23);
            default:              word = double_to_dsp(operand, 31);
         endcase
         pending_words.push_back(word);
      endfunction

      task check_result(logic [63:0] got);
         logic [63:0] want;
         if (pending_words.size() == 0) begin
            report_mismatch("result beat with nothing expected", 64'd0, got);
            return;
         end
         want = pending_words.pop_front();
         if (got !== want) report_mismatch("result", want, got);
      endtask

      task report_mismatch(string what, logic [63:0] want, logic [63:0] got);
         $display("MISMATCH %s: expected %h got %h at %0t", what, want, got, $time);
         error_count++;
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [1:0]  req_kind = 2'd0;
   logic [63:0] req_operand = 64'd0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [63:0] rsp_result;

   conversion_scoreboard board = new();
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int idle_cycles = 0;

   dsp_float_format_converter uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Note request beats and check result beats on every edge; also the watchdog
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            board.note_request(dffc_pkg::kind_type'(req_kind), req_operand);
         if (rsp_valid && !rsp_stall) board.check_result(rsp_result);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= IdleLimit) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   // Receiver stall: redraw every edge from the current percentage
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
   end

   // Drive one request beat, with optional leading idle cycles; hold until accepted
   task automatic send_beat(dffc_pkg::kind_type kind, logic [63:0] operand);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_kind    <= kind;
      req_operand <= operand;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic pause_line();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Random double biased towards interesting exponents and fractions
   function automatic logic [63:0] random_double();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      case ($urandom_range(7))
         0: bits[62:52] = 11'd0;
         1: bits[62:52] = 11'h7FF;
         2: bits[62:52] = 11'(dffc_pkg::DblBias + $urandom_range(140) - 70);
         3: bits[62:52] = 11'(dffc_pkg::DblBias - 127 + $urandom_range(1) * 254
                              + $urandom_range(2) - 1);
         4: bits[51:0] = $urandom_range(1) ? 52'd0 : 52'(($urandom_range(3)) << 20);
         default: ;
      endcase
      return bits;
   endfunction

   function automatic logic [63:0] random_dsp();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      case ($urandom_range(5))
         0: bits[31:24] = dffc_pkg::ExpZero;
         1: bits[39:32] = dffc_pkg::ExpZero;
         2: bits[22:0] = 23'd0;
         3: bits[30:0] = 31'd0;
         default: ;
      endcase
      return bits;
   endfunction

   task automatic run_random(int count);
      dffc_pkg::kind_type kind;
      repeat (count) begin
         kind = dffc_pkg::kind_type'($urandom_range(3));
         if (kind == dffc_pkg::KIND_DEC32 || kind == dffc_pkg::KIND_DEC40)
            send_beat(kind, random_dsp());
         else send_beat(kind, random_double());
      end
      pause_line();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: decode zero, signs, extremes, ignored upper bits
      send_beat(dffc_pkg::KIND_DEC32, 64'h0000_0000_8000_0000);
      send_beat(dffc_pkg::KIND_DEC32, 64'hFFFF_FFFF_7F80_0000);
      send_beat(dffc_pkg::KIND_DEC32, 64'h0000_0000_7F7F_FFFF);
      send_beat(dffc_pkg::KIND_DEC32, 64'h0000_0000_817F_FFFF);
      send_beat(dffc_pkg::KIND_DEC32, 64'h0000_0000_0000_0001);
      send_beat(dffc_pkg::KIND_DEC40, 64'h0000_0080_0000_0000);
      send_beat(dffc_pkg::KIND_DEC40, 64'hFFFF_FF7F_8000_0000);
      send_beat(dffc_pkg::KIND_DEC40, 64'h0000_0081_7FFF_FFFF);
      send_beat(dffc_pkg::KIND_DEC40, 64'h0000_007F_FFFF_FFFF);
      // Directed: encode zeros, infinities, NaN, denormals, range clamps, rounding
      send_beat(dffc_pkg::KIND_ENC32, 64'h0000_0000_0000_0000);
      send_beat(dffc_pkg::KIND_ENC32, 64'h8000_0000_0000_0000);
      send_beat(dffc_pkg::KIND_ENC32, 64'h7FF0_0000_0000_0000);
      send_beat(dffc_pkg::KIND_ENC32, 64'hFFF0_0000_0000_0000);
      send_beat(dffc_pkg::KIND_ENC32, 64'hFFF8_0000_0000_0001);
      send_beat(dffc_pkg::KIND_ENC32, 64'h0000_0000_0000_0001);
      send_beat(dffc_pkg::KIND_ENC32, 64'h000F_FFFF_FFFF_FFFF);
      send_beat(dffc_pkg::KIND_ENC32, 64'h7FEF_FFFF_FFFF_FFFF);
      send_beat(dffc_pkg::KIND_ENC32, 64'hBFF0_0000_0000_0000);
      send_beat(dffc_pkg::KIND_ENC32, 64'h3FF0_0000_1000_0000);
      send_beat(dffc_pkg::KIND_ENC40, 64'hC000_0000_0000_0000);
      send_beat(dffc_pkg::KIND_ENC40, 64'h3FFF_FFFF_FFFF_FFFF);
      send_beat(dffc_pkg::KIND_ENC40, 64'h8000_0000_0000_0003);
      send_beat(dffc_pkg::KIND_ENC40, 64'h7FF0_0000_0000_0001);
      pause_line();

      // Hold the sender until the pipe has drained completely
      while (board.pending_words.size() != 0) @(posedge clock);

      send_idle_pct = 16; recv_stall_pct = 86;
      run_random(320);
      send_idle_pct = 86; recv_stall_pct = 16;
      run_random(320);
      send_idle_pct = 0; recv_stall_pct = 0;
      run_random(310);

      while (board.pending_words.size() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
      if (board.error_count == 0) $display("CHECK OK");
      else $display("CHECK FAILED");
      $finish;
   end
endmodule

// ===== files.f =====
rtl/core/dffc_pkg.sv
rtl/core/dffc_classify.sv
rtl/core/dffc_normalise.sv
rtl/core/dffc_pack.sv
rtl/core/dsp_float_format_converter.sv
verif/dsp_float_format_converter_tb.sv
